// ----- rtl/hesc_pkg.sv -----
// ----------------------------------------------------------------------------
// hesc_pkg
// shared types, codes and defaults of the hierarchical escape symbol coder
// ----------------------------------------------------------------------------
package hesc_pkg;

    localparam int DEF_MAX_SYMBOLS   = 256;
    localparam int DEF_MAX_LEVELS    = 64;
    localparam int DEF_MAX_CODE_BITS = 16;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_SLOTS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTINUE_POS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT    = 3'd4;

    localparam logic [8:0]  RST_SYMBOL_COUNT   = 9'd256;
    localparam logic [15:0] RST_DIRECT_SLOTS   = 16'd15;
    localparam logic [4:0]  RST_BITS_PER_LEVEL = 5'd4;
    localparam logic [15:0] RST_CONTINUE_POS   = 16'd15;
    localparam logic [6:0]  RST_LEVEL_COUNT    = 7'd18;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ENCODE  = 2'd1;
    localparam logic [1:0] OP_DECODE  = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_INVALID   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CLEAR,
        ST_ENC_LOOK,
        ST_ENC_INIT,
        ST_ENC_DIV,
        ST_ENC_CHK,
        ST_ENC_EMIT,
        ST_DEC_CHK,
        ST_DEC_RANK,
        ST_DEC_OUT
    } state_t;

endpackage

// ----- rtl/hesc_ram.sv -----
// ----------------------------------------------------------------------------
// hesc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hesc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/hierarchical_escape_symbol_coder.sv -----
// ----------------------------------------------------------------------------
// hierarchical_escape_symbol_coder
// rank table coder that spreads ranks over levels of escape codewords
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; busy stays high
// until the operation has finished and its last word has been registered.
// Results appear on code_out, symbol_out, status and last for one cycle,
// marked by result_valid; the receiver cannot stall them.
// Configuration words go in on cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high; the user must see that writes are only made while the block
// is idle, which the block does not enforce. Load and restart: ST_LOAD or
// ST_CLEAR registers the result. Decode: ST_DEC_CHK, ST_DEC_RANK, then
// ST_DEC_OUT gives the symbol; a failed check ends early with an invalid
// word, and a continue codeword that keeps the walk going gives no word
// and frees the block. Encode: one table read, an 8 step restoring divide
// of the rank by direct_slots, a depth check, then level+1 words on
// consecutive cycles; an unloaded symbol or a failed check ends it early.
// Reset clears the loaded marks, load counter, decode level and registers
// to their defaults; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module hierarchical_escape_symbol_coder #(
    parameter int MAX_SYMBOLS   = hesc_pkg::DEF_MAX_SYMBOLS,
    parameter int MAX_LEVELS    = hesc_pkg::DEF_MAX_LEVELS,
    parameter int MAX_CODE_BITS = hesc_pkg::DEF_MAX_CODE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     operation,
    input  logic [7:0]                     symbol_id,
    input  logic [15:0]                    codeword,
    output logic                           result_valid,
    output logic [15:0]                    code_out,
    output logic [7:0]                     symbol_out,
    output logic [1:0]                     status,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hesc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);

    localparam int TBL_DEPTH = (MAX_SYMBOLS < 256) ? MAX_SYMBOLS : 256;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    localparam logic [31:0] MAX_SYM_U = 32'(MAX_SYMBOLS);
    localparam logic [6:0]  MAX_LEV_U = 7'(MAX_LEVELS);
    localparam logic [5:0]  MAX_CB_U  = 6'(MAX_CODE_BITS);

    hesc_pkg::state_t state_reg, state_next;

    logic [8:0]  sc_reg;
    logic [15:0] ds_reg;
    logic [4:0]  bpl_reg;
    logic [15:0] cp_reg;
    logic [6:0]  lc_reg;

    logic [1:0]  op_reg;
    logic [7:0]  sid_reg;
    logic [15:0] cw_reg;

    logic [TBL_DEPTH-1:0] loaded_reg;
    logic [8:0]  load_idx_reg;
    logic [5:0]  dec_level_reg;

    logic [7:0]  quo_reg;
    logic [7:0]  rem_reg;
    logic [5:0]  cnt_reg;
    logic [21:0] prod_reg;

    logic        res_valid_reg;
    logic [15:0] res_code_reg;
    logic [7:0]  res_sym_reg;
    logic [1:0]  res_status_reg;
    logic        res_last_reg;

    // combinational results of the fsm
    logic        emit;
    logic [15:0] emit_code;
    logic [7:0]  emit_sym;
    logic [1:0]  emit_status;
    logic        emit_last;

    logic [15:0] cw_mask;
    logic        width_ok;
    logic [6:0]  eff_lev;
    logic        sid_in_range;
    logic        sid_loaded;
    logic        load_ok;
    logic [15:0] dec_pos;
    logic [22:0] dec_rank;
    logic        rank_ok;
    logic [8:0]  div_trial;
    logic        div_ge;
    logic [7:0]  div_rem;

    logic [7:0]  s2r_rdata;
    logic [7:0]  r2s_rdata;
    logic        s2r_rd_en;
    logic        r2s_rd_en;
    logic        tbl_wr_en;

    assign cw_mask  = 16'((17'd1 << bpl_reg) - 17'd1);
    assign width_ok = (bpl_reg != 5'd0) && ({1'b0, bpl_reg} <= MAX_CB_U)
                      && (bpl_reg <= 5'd16);
    assign eff_lev  = (lc_reg < MAX_LEV_U) ? lc_reg : MAX_LEV_U;

    assign sid_in_range = ({1'b0, sid_reg} < sc_reg) && ({24'd0, sid_reg} < MAX_SYM_U);
    assign sid_loaded   = loaded_reg[sid_reg[TBL_AW-1:0]];
    assign load_ok      = (load_idx_reg < sc_reg) && ({23'd0, load_idx_reg} < MAX_SYM_U)
                          && sid_in_range && !sid_loaded;

    assign dec_pos  = cw_reg & cw_mask;
    assign dec_rank = {1'b0, prod_reg} + {7'd0, dec_pos};
    assign rank_ok  = (dec_rank < {14'd0, sc_reg}) && ({9'd0, dec_rank} < MAX_SYM_U);

    assign div_trial = {rem_reg, quo_reg[7]};
    assign div_ge    = {8'd0, div_trial} >= {1'b0, ds_reg};
    assign div_rem   = div_ge ? 8'(div_trial - ds_reg[8:0]) : div_trial[7:0];

    hesc_ram #(
        .WIDTH (8),
        .DEPTH (TBL_DEPTH)
    ) u_sym_to_rank (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (sid_reg[TBL_AW-1:0]),
        .wr_data (load_idx_reg[7:0]),
        .rd_en   (s2r_rd_en),
        .rd_addr (sid_reg[TBL_AW-1:0]),
        .rd_data (s2r_rdata)
    );

    hesc_ram #(
        .WIDTH (8),
        .DEPTH (TBL_DEPTH)
    ) u_rank_to_sym (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (load_idx_reg[TBL_AW-1:0]),
        .wr_data (sid_reg),
        .rd_en   (r2s_rd_en),
        .rd_addr (dec_rank[TBL_AW-1:0]),
        .rd_data (r2s_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hesc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        emit        = 1'b0;
        emit_code   = 16'd0;
        emit_sym    = 8'd0;
        emit_status = hesc_pkg::STAT_OK;
        emit_last   = 1'b1;
        s2r_rd_en   = 1'b0;
        r2s_rd_en   = 1'b0;
        tbl_wr_en   = 1'b0;
        case (state_reg)
            hesc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        hesc_pkg::OP_LOAD:   state_next = hesc_pkg::ST_LOAD;
                        hesc_pkg::OP_ENCODE: state_next = hesc_pkg::ST_ENC_LOOK;
                        hesc_pkg::OP_DECODE: state_next = hesc_pkg::ST_DEC_CHK;
                        default:             state_next = hesc_pkg::ST_CLEAR;
                    endcase
                end
            end
            hesc_pkg::ST_LOAD:
            begin
                emit       = 1'b1;
                tbl_wr_en  = load_ok;
                emit_status = load_ok ? hesc_pkg::STAT_OK : hesc_pkg::STAT_INVALID;
                state_next = hesc_pkg::ST_IDLE;
            end
            hesc_pkg::ST_CLEAR:
            begin
                emit       = 1'b1;
                state_next = hesc_pkg::ST_IDLE;
            end
            hesc_pkg::ST_ENC_LOOK:
            begin
                if (!(sid_in_range && sid_loaded))
                begin
                    emit        = 1'b1;
                    emit_status = hesc_pkg::STAT_NOT_FOUND;
                    state_next  = hesc_pkg::ST_IDLE;
                end
                else if (!width_ok || ds_reg == 16'd0)
                begin
                    emit        = 1'b1;
                    emit_status = hesc_pkg::STAT_INVALID;
                    state_next  = hesc_pkg::ST_IDLE;
                end
                else
                begin
                    s2r_rd_en  = 1'b1;
                    state_next = hesc_pkg::ST_ENC_INIT;
                end
            end
            hesc_pkg::ST_ENC_INIT:
            begin
                state_next = hesc_pkg::ST_ENC_DIV;
            end
            hesc_pkg::ST_ENC_DIV:
            begin
                if (cnt_reg[2:0] == 3'd7)
                begin
                    state_next = hesc_pkg::ST_ENC_CHK;
                end
            end
            hesc_pkg::ST_ENC_CHK:
            begin
                if (quo_reg >= {1'b0, eff_lev})
                begin
                    emit        = 1'b1;
                    emit_status = hesc_pkg::STAT_INVALID;
                    state_next  = hesc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = hesc_pkg::ST_ENC_EMIT;
                end
            end
            hesc_pkg::ST_ENC_EMIT:
            begin
                emit = 1'b1;
                if (cnt_reg == quo_reg[5:0])
                begin
                    emit_code  = {8'd0, rem_reg} & cw_mask;
                    state_next = hesc_pkg::ST_IDLE;
                end
                else
                begin
                    emit_code = cp_reg & cw_mask;
                    emit_last = 1'b0;
                end
            end
            hesc_pkg::ST_DEC_CHK:
            begin
                if (!width_ok || ds_reg == 16'd0 || {1'b0, dec_level_reg} >= eff_lev)
                begin
                    emit        = 1'b1;
                    emit_status = hesc_pkg::STAT_INVALID;
                    state_next  = hesc_pkg::ST_IDLE;
                end
                else if (dec_pos < ds_reg)
                begin
                    state_next = hesc_pkg::ST_DEC_RANK;
                end
                else if (dec_pos == cp_reg && ({1'b0, dec_level_reg} + 7'd1) < eff_lev)
                begin
                    state_next = hesc_pkg::ST_IDLE;
                end
                else
                begin
                    emit        = 1'b1;
                    emit_status = hesc_pkg::STAT_INVALID;
                    state_next  = hesc_pkg::ST_IDLE;
                end
            end
            hesc_pkg::ST_DEC_RANK:
            begin
                if (rank_ok)
                begin
                    r2s_rd_en  = 1'b1;
                    state_next = hesc_pkg::ST_DEC_OUT;
                end
                else
                begin
                    emit        = 1'b1;
                    emit_status = hesc_pkg::STAT_INVALID;
                    state_next  = hesc_pkg::ST_IDLE;
                end
            end
            hesc_pkg::ST_DEC_OUT:
            begin
                emit       = 1'b1;
                emit_sym   = r2s_rdata;
                state_next = hesc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = hesc_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg        <= hesc_pkg::RST_SYMBOL_COUNT;
            ds_reg        <= hesc_pkg::RST_DIRECT_SLOTS;
            bpl_reg       <= hesc_pkg::RST_BITS_PER_LEVEL;
            cp_reg        <= hesc_pkg::RST_CONTINUE_POS;
            lc_reg        <= hesc_pkg::RST_LEVEL_COUNT;
            loaded_reg    <= '0;
            load_idx_reg  <= 9'd0;
            dec_level_reg <= 6'd0;
            cnt_reg       <= 6'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= emit;
            if (cfg_valid)
            begin
                case (cfg_index)
                    hesc_pkg::CFG_SYMBOL_COUNT:   sc_reg  <= cfg_data[8:0];
                    hesc_pkg::CFG_DIRECT_SLOTS:   ds_reg  <= cfg_data;
                    hesc_pkg::CFG_BITS_PER_LEVEL: bpl_reg <= cfg_data[4:0];
                    hesc_pkg::CFG_CONTINUE_POS:   cp_reg  <= cfg_data;
                    hesc_pkg::CFG_LEVEL_COUNT:    lc_reg  <= cfg_data[6:0];
                    default:                      ;
                endcase
            end
            case (state_reg)
                hesc_pkg::ST_LOAD:
                begin
                    if (load_ok)
                    begin
                        loaded_reg[sid_reg[TBL_AW-1:0]] <= 1'b1;
                        load_idx_reg <= load_idx_reg + 9'd1;
                    end
                end
                hesc_pkg::ST_CLEAR:
                begin
                    loaded_reg    <= '0;
                    load_idx_reg  <= 9'd0;
                    dec_level_reg <= 6'd0;
                end
                hesc_pkg::ST_ENC_INIT:
                begin
                    cnt_reg <= 6'd0;
                end
                hesc_pkg::ST_ENC_DIV:
                begin
                    cnt_reg <= (cnt_reg[2:0] == 3'd7) ? 6'd0 : cnt_reg + 6'd1;
                end
                hesc_pkg::ST_ENC_EMIT:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
                hesc_pkg::ST_DEC_CHK:
                begin
                    if (state_next == hesc_pkg::ST_IDLE && !emit)
                    begin
                        dec_level_reg <= dec_level_reg + 6'd1;
                    end
                    else
                    begin
                        dec_level_reg <= 6'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == hesc_pkg::ST_IDLE && start)
        begin
            op_reg  <= operation;
            sid_reg <= symbol_id;
            cw_reg  <= codeword;
        end
        case (state_reg)
            hesc_pkg::ST_ENC_INIT:
            begin
                quo_reg <= s2r_rdata;
                rem_reg <= 8'd0;
            end
            hesc_pkg::ST_ENC_DIV:
            begin
                quo_reg <= {quo_reg[6:0], div_ge};
                rem_reg <= div_rem;
            end
            hesc_pkg::ST_DEC_CHK:
            begin
                prod_reg <= {16'd0, dec_level_reg} * {6'd0, ds_reg};
            end
            default:
            begin
            end
        endcase
        if (emit)
        begin
            res_code_reg   <= emit_code;
            res_sym_reg    <= emit_sym;
            res_status_reg <= emit_status;
            res_last_reg   <= emit_last;
        end
    end

    assign busy         = (state_reg != hesc_pkg::ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign code_out     = res_code_reg;
    assign symbol_out   = res_sym_reg;
    assign status       = res_status_reg;
    assign last         = res_last_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op_reg == op_reg) |=> busy)
        else $error("accepted operation did not raise busy");

    a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(state_reg) != hesc_pkg::ST_IDLE))
        else $error("result word without an operation in progress");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, dec_level_reg} < MAX_LEV_U))
        else $error("decode level beyond the level limit");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(loaded_reg) == int'(load_idx_reg)))
        else $error("load counter and loaded marks disagree");

    a_continue_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hesc_pkg::ST_ENC_EMIT && cnt_reg != quo_reg[5:0])
        |=> (result_valid && !last))
        else $error("continue word missing or marked last");

endmodule
